// ----- sv/lcs_pkg.sv -----
package lcs_pkg;

  localparam int unsigned MaxLeds = 16;
  localparam int unsigned PosW    = 5;
  localparam int unsigned MaskW   = 16;
  localparam int unsigned AddrW   = 11;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  localparam logic [CfgIdxW-1:0] CfgBaseAddr = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPattern  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLedCount = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTimeOn   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTimeOff  = 3'd4;

  localparam logic [1:0] PatDot    = 2'd0;
  localparam logic [1:0] PatFill   = 2'd1;
  localparam logic [1:0] PatClear  = 2'd2;
  localparam logic [1:0] PatBounce = 2'd3;

  localparam logic ActTick    = 1'b0;
  localparam logic ActCommand = 1'b1;

  typedef struct packed {
    logic [AddrW-1:0] base_addr;
    logic [1:0]       pattern;
    logic [PosW-1:0]  led_count;
    logic [TimeW-1:0] time_on;
    logic [TimeW-1:0] time_off;
  } lcs_cfg_t;

  typedef struct packed {
    logic [MaskW-1:0] lit;
    logic [PosW-1:0]  next_pos;
    logic [PosW-1:0]  last_pos;
    logic             moving_up;
    logic             chain_fin;
    logic             active;
    logic             phase;
    logic [TimeW-1:0] ticks;
  } lcs_state_t;

  function automatic logic [MaskW-1:0] led_bit(logic [PosW-1:0] pos);
    logic [MaskW-1:0] m;
    m = '0;
    if (pos < PosW'(MaxLeds)) begin
      m[pos[3:0]] = 1'b1;
    end
    return m;
  endfunction

endpackage

// ----- sv/lcs_step.sv -----
module lcs_step (
  input  lcs_pkg::lcs_cfg_t   cfg_i,
  input  lcs_pkg::lcs_state_t state_i,
  input  logic                action_i,
  input  logic [10:0]         address_i,
  input  logic                command_i,
  output lcs_pkg::lcs_state_t state_o
);
  import lcs_pkg::*;

  logic [PosW-1:0] n;
  lcs_state_t      st;

  always_comb begin
    if (cfg_i.led_count == '0) begin
      n = PosW'(1);
    end else if (cfg_i.led_count > PosW'(MaxLeds)) begin
      n = PosW'(MaxLeds);
    end else begin
      n = cfg_i.led_count;
    end
  end

  always_comb begin
    st = state_i;
    if (action_i == ActCommand) begin
      if (address_i == cfg_i.base_addr && st.active != command_i) begin
        if (command_i) begin
          st.active    = 1'b1;
          st.ticks     = cfg_i.time_on;
          st.phase     = 1'b0;
          st.next_pos  = '0;
          st.last_pos  = '0;
          st.chain_fin = 1'b0;
        end else begin
          st.active = 1'b0;
          st.lit    = '0;
        end
      end
    end else if (st.active) begin
      if (st.ticks <= TimeW'(1)) begin
        case (cfg_i.pattern)
          PatDot: begin
            if (st.next_pos >= n) begin
              st.next_pos = '0;
            end
            if (st.last_pos != st.next_pos) begin
              st.lit      = st.lit & ~led_bit(st.last_pos);
              st.last_pos = st.next_pos;
            end
            st.lit      = st.lit | led_bit(st.next_pos);
            st.next_pos = st.next_pos + PosW'(1);
            if (st.next_pos >= n) begin
              st.next_pos = '0;
            end
          end
          PatFill: begin
            if (!st.chain_fin) begin
              if (st.next_pos < n) begin
                st.lit = st.lit | led_bit(st.next_pos);
              end
              if (st.next_pos <= n) begin
                st.next_pos = st.next_pos + PosW'(1);
              end
              if (st.next_pos > n) begin
                st.chain_fin = 1'b1;
              end
            end else begin
              st.lit       = '0;
              st.next_pos  = '0;
              st.chain_fin = 1'b0;
            end
          end
          PatClear: begin
            if (st.next_pos < n) begin
              st.lit      = st.lit | led_bit(st.next_pos);
              st.next_pos = st.next_pos + PosW'(1);
            end else if (st.last_pos < n) begin
              st.lit      = st.lit & ~led_bit(st.last_pos);
              st.last_pos = st.last_pos + PosW'(1);
            end else begin
              st.next_pos = '0;
              st.last_pos = '0;
            end
          end
          default: begin
            if (st.next_pos >= n) begin
              st.next_pos = n - PosW'(1);
            end
            if (st.last_pos != st.next_pos) begin
              st.lit      = st.lit & ~led_bit(st.last_pos);
              st.last_pos = st.next_pos;
            end
            st.lit = st.lit | led_bit(st.next_pos);
            if (st.moving_up) begin
              st.next_pos = st.next_pos + PosW'(1);
            end else if (st.next_pos > '0) begin
              st.next_pos = st.next_pos - PosW'(1);
            end
            if (st.next_pos >= n && st.moving_up) begin
              st.next_pos  = n - PosW'(1);
              st.moving_up = 1'b0;
            end
            if (st.next_pos == '0 && !st.moving_up) begin
              st.moving_up = 1'b1;
            end
          end
        endcase
        st.ticks = st.phase ? cfg_i.time_on : cfg_i.time_off;
        st.phase = ~st.phase;
      end else begin
        st.ticks = st.ticks - TimeW'(1);
      end
    end
  end

  assign state_o = st;

endmodule

// ----- sv/led_chaser_sequencer_top.sv -----
// Running-light sequencer for a chain of up to sixteen LEDs.
// The slave stream carries one word per event: tuser selects a 1 ms tick (0)
// or a switch command (1); tdata holds the command's address and value.
// A command for the configured base address switches the sequencer on or
// off when it changes the active state. While on, the interval timer runs
// time_on and time_off ticks in turn and each expiry steps the pattern.
// Every input word yields exactly one output word with the LED mask and
// the running flag.
// The input word is registered, then its result word is registered once the
// result register is empty or being read; each register holds one word, so a new
// word is accepted in every cycle while the result side keeps taking them.
// When the receiver stalls the result word holds and at most one further
// word is taken into the input register before tready falls.
// Reset resets the valid flags and sequencer state, holds tready low and loads the
// defaults (base address 0, single dot pattern, 16 LEDs, 500 ticks on and off).
// Configuration writes are taken at any edge with the write enable high,
// and are meant to happen only while no word is in flight.
module led_chaser_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [10:0] address, [11] command, [15:12] zero
  input  logic        s_axis_tuser_i,   // [0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [15:0] led_mask, [16] running, [23:17] zero
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import lcs_pkg::*;

  lcs_cfg_t   cfg_q;
  lcs_state_t st_q, st_d;

  logic        en_q;
  logic        in_valid_q;
  logic        in_action_q;
  logic [10:0] in_addr_q;
  logic        in_cmd_q;
  logic        out_valid_q;
  logic [16:0] out_data_q;
  logic        advance;
  logic        in_take;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = en_q && (!in_valid_q || advance);
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_addr <= '0;
      cfg_q.pattern   <= PatDot;
      cfg_q.led_count <= PosW'(16);
      cfg_q.time_on   <= TimeW'(500);
      cfg_q.time_off  <= TimeW'(500);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBaseAddr: cfg_q.base_addr <= cfg_data_i[AddrW-1:0];
        CfgPattern:  cfg_q.pattern   <= cfg_data_i[1:0];
        CfgLedCount: cfg_q.led_count <= cfg_data_i[PosW-1:0];
        CfgTimeOn:   cfg_q.time_on   <= cfg_data_i;
        CfgTimeOff:  cfg_q.time_off  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= 1'b0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      en_q <= 1'b1;
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_action_q <= s_axis_tuser_i;
      in_addr_q   <= s_axis_tdata_i[10:0];
      in_cmd_q    <= s_axis_tdata_i[11];
    end
    if (advance) begin
      out_data_q <= {st_d.active, st_d.lit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.lit       <= '0;
      st_q.next_pos  <= '0;
      st_q.last_pos  <= '0;
      st_q.moving_up <= 1'b1;
      st_q.chain_fin <= 1'b0;
      st_q.active    <= 1'b0;
      st_q.phase     <= 1'b0;
      st_q.ticks     <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  lcs_step u_step (
    .cfg_i     (cfg_q),
    .state_i   (st_q),
    .action_i  (in_action_q),
    .address_i (in_addr_q),
    .command_i (in_cmd_q),
    .state_o   (st_d)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_data_q};

endmodule

// ----- sv/lcs_checker.sv -----
module lcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o
);

  // A sequencer that is not running keeps every LED dark.
  a_dark_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[16] |-> m_axis_tdata_o[15:0] == 16'h0000)
    else $error("LEDs lit while the sequencer is stopped");

  // A stalled result word holds its value.
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // With the result side empty the input side is always ready to take a word.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input not ready although no result is pending");

  // Nothing is offered or taken in the cycle after reset has been seen.
  a_quiet_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o && !s_axis_tready_o)
    else $error("handshake active during reset");

endmodule

bind led_chaser_sequencer_top lcs_checker u_lcs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
